>>> rtl/steering_pid_differential_drive_macros.svh
// Assertion macros for the steering PID block.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef STEERING_PID_DIFFERENTIAL_DRIVE_MACROS_SVH
`define STEERING_PID_DIFFERENTIAL_DRIVE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPDD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPDD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/spdd_pkg.sv
// Package for the steering PID block: word types, config set, microcode types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spdd_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int HIST_IDX_W    = $clog2(HISTORY_DEPTH);
  localparam logic [3:0] LAG_MAX = 4'(HISTORY_DEPTH - 1);

  localparam logic [9:0] PROTECT_LIMIT = 10'd750;
  localparam logic [9:0] COUNT_MAX     = 10'd1023;
  localparam logic [9:0] LOST_LINE_SUM = 10'd80;
  localparam logic signed [16:0] TRACK_TOL = 17'sd10;
  localparam logic signed [15:0] ERR_SCALE = 16'sd100;

  // Division by 100 as multiply by ceil(2^33/100), exact for 26-bit numerators
  localparam int RECIP_SH = 33;
  localparam logic signed [27:0] RECIP_M = 28'sd85899346;

  localparam int MUL_A_W = 26;
  localparam int MUL_B_W = 28;
  localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
  localparam int ACC_W   = 36;

  localparam int PC_W = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SECOND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_LAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_LIMIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT_ENABLE = 3'd6;

  typedef struct packed {
    logic [7:0]         sensor_left;
    logic [7:0]         sensor_right;
    logic [9:0]         sensor_sum;
    logic signed [11:0] count_left;
    logic signed [11:0] count_right;
    logic               release_stop;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] steer_out;
    logic signed [15:0] left_target;
    logic signed [15:0] right_target;
    logic               stopped;
  } out_word_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_second_diff;
    logic [15:0] gain_d;
    logic [3:0]  deriv_lag;
    logic [14:0] steer_limit;
    logic [10:0] base_speed;
    logic        protect_enable;
  } cfg_t;

  typedef enum logic [2:0] {A_GP, A_GS, A_GD, A_BASE, A_MAG} a_sel_e;
  typedef enum logic [2:0] {B_E0, B_SD, B_DD, B_STEER, B_RECIP} b_sel_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_e;
  typedef enum logic [1:0] {J_NONE, J_NO_INPUT, J_OUT_BUSY} jmp_e;

  typedef struct packed {
    a_sel_e          a_sel;
    b_sel_e          b_sel;
    logic            mul_en;
    acc_op_e         acc_op;
    logic            steer_en;
    logic            mag_en;
    logic            out_en;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  localparam ctl_t CTL_NOP = '{
    a_sel:    A_GP,
    b_sel:    B_E0,
    mul_en:   1'b0,
    acc_op:   ACC_HOLD,
    steer_en: 1'b0,
    mag_en:   1'b0,
    out_en:   1'b0,
    jmp:      J_NONE,
    target:   '0,
    last:     1'b0
  };

endpackage

`default_nettype wire

>>> rtl/steering_pid_differential_drive.sv
// Steering PID with differential-drive wheel targets: top level and config registers.
// Depends on spdd_pkg, spdd_seq, spdd_datapath and the assertion macro header.
//
// Use: one input word per control tick on in_valid_i/in_stall_o/in_word_i; one
// output word per tick on out_valid_o/out_stall_i/out_word_o. A word moves at a
// clock edge where valid is high and stall is low.
// The output word is registered at the last step of the ten-step microprogram,
// which runs all five products through one shared 27x28 multiplier; a new input
// word is taken only once the sequencer is back in its wait step.
// in_stall_o is high while a word is being worked on. If the receiver stalls,
// the finished word holds in the output register; the sequencer waits on its
// last step only while a new result would overwrite a word not yet taken.
// Configuration: cfg_we_i, cfg_index_i, cfg_wdata_i write one register per
// cycle; write only while the block is idle.
// Reset: asynchronous, active low; clears the error history, protection counter
// and previous targets, sets the stop flag, loads the config reset values.
`timescale 1ns / 1ps
`default_nettype none
`include "steering_pid_differential_drive_macros.svh"

module steering_pid_differential_drive (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire spdd_pkg::in_word_t                     in_word_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output spdd_pkg::out_word_t                         out_word_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic [spdd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [spdd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);

  spdd_pkg::cfg_t     cfg_q;
  spdd_pkg::ctl_t     ctl;
  spdd_pkg::dp_stat_t stat;
  logic               idle;
  logic               accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p           <= 16'd256;
      cfg_q.gain_second_diff <= 16'd0;
      cfg_q.gain_d           <= 16'd0;
      cfg_q.deriv_lag        <= 4'd1;
      cfg_q.steer_limit      <= 15'd1000;
      cfg_q.base_speed       <= 11'd0;
      cfg_q.protect_enable   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spdd_pkg::CFG_GAIN_P:         cfg_q.gain_p           <= cfg_wdata_i;
        spdd_pkg::CFG_GAIN_SECOND:    cfg_q.gain_second_diff <= cfg_wdata_i;
        spdd_pkg::CFG_GAIN_D:         cfg_q.gain_d           <= cfg_wdata_i;
        spdd_pkg::CFG_DERIV_LAG:      cfg_q.deriv_lag        <= cfg_wdata_i[3:0];
        spdd_pkg::CFG_STEER_LIMIT:    cfg_q.steer_limit      <= cfg_wdata_i[14:0];
        spdd_pkg::CFG_BASE_SPEED:     cfg_q.base_speed       <= cfg_wdata_i[10:0];
        spdd_pkg::CFG_PROTECT_ENABLE: cfg_q.protect_enable   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign accept     = in_valid_i && idle;
  assign in_stall_o = !idle;

  spdd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctl_o      (ctl),
    .idle_o     (idle)
  );

  spdd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ctl_i       (ctl),
    .accept_i    (accept),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  `SPDD_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")
  `SPDD_ASSERT_IMP(a_rose_out_idle, $rose(out_valid_o), !in_stall_o, "result without return to idle")
  `SPDD_ASSERT_IMP(a_idle_has_result, $fell(in_stall_o), out_valid_o, "idle without a result word")

endmodule

`default_nettype wire

>>> rtl/spdd_seq.sv
// Microcode sequencer: step counter, control-word ROM, conditional jumps.
// Depends on spdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdd_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire spdd_pkg::dp_stat_t stat_i,
  output spdd_pkg::ctl_t         ctl_o,
  output logic                   idle_o
);

  localparam logic [spdd_pkg::PC_W-1:0] STEP_WAIT = 4'd0;
  localparam logic [spdd_pkg::PC_W-1:0] STEP_OUT  = 4'd9;

  logic [spdd_pkg::PC_W-1:0] pc_q, pc_d;
  spdd_pkg::ctl_t            ctl;
  logic                      take;

  function automatic spdd_pkg::ctl_t rom_word(input logic [spdd_pkg::PC_W-1:0] pc);
    spdd_pkg::ctl_t w;
    w = spdd_pkg::CTL_NOP;
    unique case (pc)
      4'd0: begin
        w.jmp    = spdd_pkg::J_NO_INPUT;
        w.target = STEP_WAIT;
      end
      4'd1: begin
        w.a_sel  = spdd_pkg::A_GP;
        w.b_sel  = spdd_pkg::B_E0;
        w.mul_en = 1'b1;
      end
      4'd2: begin
        w.a_sel  = spdd_pkg::A_GS;
        w.b_sel  = spdd_pkg::B_SD;
        w.mul_en = 1'b1;
        w.acc_op = spdd_pkg::ACC_LOAD;
      end
      4'd3: begin
        w.a_sel  = spdd_pkg::A_GD;
        w.b_sel  = spdd_pkg::B_DD;
        w.mul_en = 1'b1;
        w.acc_op = spdd_pkg::ACC_ADD;
      end
      4'd4: begin
        w.acc_op = spdd_pkg::ACC_ADD;
      end
      4'd5: begin
        w.steer_en = 1'b1;
      end
      4'd6: begin
        w.a_sel  = spdd_pkg::A_BASE;
        w.b_sel  = spdd_pkg::B_STEER;
        w.mul_en = 1'b1;
      end
      4'd7: begin
        w.mag_en = 1'b1;
      end
      4'd8: begin
        w.a_sel  = spdd_pkg::A_MAG;
        w.b_sel  = spdd_pkg::B_RECIP;
        w.mul_en = 1'b1;
      end
      4'd9: begin
        w.out_en = 1'b1;
        w.jmp    = spdd_pkg::J_OUT_BUSY;
        w.target = STEP_OUT;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  assign ctl = rom_word(pc_q);

  always_comb begin
    unique case (ctl.jmp)
      spdd_pkg::J_NO_INPUT: take = !in_valid_i;
      spdd_pkg::J_OUT_BUSY: take = stat_i.out_busy;
      default:              take = 1'b0;
    endcase
    if (take) begin
      pc_d = ctl.target;
    end else if (ctl.last) begin
      pc_d = STEP_WAIT;
    end else begin
      pc_d = pc_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o  = ctl;
  assign idle_o = (pc_q == STEP_WAIT);

endmodule

`default_nettype wire

>>> rtl/spdd_datapath.sv
// Datapath: error history, protection counter, shared multiplier, accumulator,
// clamp, wheel targets and output register. Depends on spdd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdd_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire spdd_pkg::cfg_t     cfg_i,
  input  wire spdd_pkg::ctl_t     ctl_i,
  input  wire logic              accept_i,
  input  wire spdd_pkg::in_word_t in_word_i,
  input  wire logic              out_stall_i,
  output spdd_pkg::dp_stat_t     stat_o,
  output logic                   out_valid_o,
  output spdd_pkg::out_word_t    out_word_o
);

  localparam int DEPTH = spdd_pkg::HISTORY_DEPTH;
  localparam int AW    = spdd_pkg::MUL_A_W;
  localparam int BW    = spdd_pkg::MUL_B_W;
  localparam int PW    = spdd_pkg::PROD_W;
  localparam int CW    = spdd_pkg::ACC_W;

  logic signed [15:0] hist_q [DEPTH];
  logic [9:0]         cnt_q, cnt_d;
  logic               stop_q, stop_d;
  logic signed [15:0] prev_l_q, prev_r_q;

  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [CW-1:0] acc_q, acc_d;
  logic signed [15:0]   steer_q, steer_d;
  logic [AW-1:0]        mag_q, mag_d;
  logic                 neg_q;
  logic                 out_valid_q;
  spdd_pkg::out_word_t  out_word_q;

  logic signed [8:0]  diff;
  logic signed [15:0] e_new;
  logic signed [15:0] e0, e1, e2, elag;
  logic [3:0]         lag_sat;
  logic signed [17:0] sd;
  logic signed [16:0] dd;
  logic [AW-1:0]      a_op;
  logic signed [BW-1:0] b_op;
  logic signed [CW-1:0] adj, shr, lim;
  logic signed [26:0] pbs;
  logic signed [26:0] pbs_abs;
  logic [19:0]        quo;
  logic signed [20:0] share;
  logic signed [21:0] lt, rt;
  logic signed [15:0] lt_sat, rt_sat;
  logic               out_wr;
  logic               out_busy;
  logic signed [16:0] dl, dr;
  logic               trk;
  logic               stop_a;
  logic [9:0]         cnt_a, cnt_b;

  function automatic logic [9:0] bump(input logic [9:0] c);
    return (c == spdd_pkg::COUNT_MAX) ? c : c + 10'd1;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Protection update and new error, evaluated on the accepted word
  always_comb begin
    diff  = $signed({1'b0, in_word_i.sensor_left}) - $signed({1'b0, in_word_i.sensor_right});
    e_new = spdd_pkg::ERR_SCALE * {{7{diff[8]}}, diff};

    stop_a = in_word_i.release_stop ? 1'b0 : stop_q;
    if (cnt_q >= spdd_pkg::PROTECT_LIMIT) begin
      stop_d = 1'b1;
      cnt_a  = '0;
    end else begin
      stop_d = stop_a;
      cnt_a  = cnt_q;
    end

    dl  = {{5{in_word_i.count_left[11]}}, in_word_i.count_left} - {prev_l_q[15], prev_l_q};
    dr  = {prev_r_q[15], prev_r_q} - {{5{in_word_i.count_right[11]}}, in_word_i.count_right};
    trk = (dl > spdd_pkg::TRACK_TOL) || (dl < -spdd_pkg::TRACK_TOL) ||
          (dr > spdd_pkg::TRACK_TOL) || (dr < -spdd_pkg::TRACK_TOL);

    cnt_b = cnt_a;
    if (cfg_i.protect_enable && !stop_d) begin
      if (trk) begin
        cnt_b = bump(cnt_a);
      end else if (in_word_i.sensor_sum > spdd_pkg::LOST_LINE_SUM) begin
        cnt_b = '0;
      end
    end
    if (cfg_i.protect_enable && (in_word_i.sensor_sum < spdd_pkg::LOST_LINE_SUM)) begin
      cnt_d = bump(cnt_b);
    end else begin
      cnt_d = cnt_b;
    end
  end

  // Operands from the shifted history
  always_comb begin
    lag_sat = (cfg_i.deriv_lag > spdd_pkg::LAG_MAX) ? spdd_pkg::LAG_MAX : cfg_i.deriv_lag;
    e0   = hist_q[0];
    e1   = hist_q[1];
    e2   = hist_q[2];
    elag = hist_q[lag_sat[spdd_pkg::HIST_IDX_W-1:0]];
    sd   = {{2{e0[15]}}, e0} - {e1[15], e1, 1'b0} + {{2{e2[15]}}, e2};
    dd   = {e0[15], e0} - {elag[15], elag};
  end

  always_comb begin
    unique case (ctl_i.a_sel)
      spdd_pkg::A_GP:   a_op = {10'd0, cfg_i.gain_p};
      spdd_pkg::A_GS:   a_op = {10'd0, cfg_i.gain_second_diff};
      spdd_pkg::A_GD:   a_op = {10'd0, cfg_i.gain_d};
      spdd_pkg::A_BASE: a_op = {15'd0, cfg_i.base_speed};
      spdd_pkg::A_MAG:  a_op = mag_q;
      default:          a_op = '0;
    endcase
    unique case (ctl_i.b_sel)
      spdd_pkg::B_E0:    b_op = {{12{e0[15]}}, e0};
      spdd_pkg::B_SD:    b_op = {{10{sd[17]}}, sd};
      spdd_pkg::B_DD:    b_op = {{11{dd[16]}}, dd};
      spdd_pkg::B_STEER: b_op = {{12{steer_q[15]}}, steer_q};
      spdd_pkg::B_RECIP: b_op = spdd_pkg::RECIP_M;
      default:           b_op = '0;
    endcase
    prod_d = $signed({1'b0, a_op}) * b_op;
  end

  always_comb begin
    unique case (ctl_i.acc_op)
      spdd_pkg::ACC_LOAD: acc_d = prod_q[CW-1:0];
      spdd_pkg::ACC_ADD:  acc_d = acc_q + prod_q[CW-1:0];
      default:            acc_d = acc_q;
    endcase
  end

  // Truncate toward zero by 256, then clamp
  always_comb begin
    adj = acc_q + (acc_q[CW-1] ? 36'sd255 : 36'sd0);
    shr = adj >>> 8;
    lim = $signed({21'd0, cfg_i.steer_limit});
    if (shr > lim) begin
      steer_d = lim[15:0];
    end else if (shr < -lim) begin
      steer_d = 16'(-lim);
    end else begin
      steer_d = shr[15:0];
    end
  end

  always_comb begin
    pbs     = prod_q[26:0];
    pbs_abs = pbs[26] ? -pbs : pbs;
    mag_d   = pbs_abs[AW-1:0];
    quo     = prod_q[spdd_pkg::RECIP_SH+19:spdd_pkg::RECIP_SH];
    share   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    lt      = $signed({11'd0, cfg_i.base_speed}) - {share[20], share};
    rt      = $signed({11'd0, cfg_i.base_speed}) + {share[20], share};
    lt_sat  = sat16(lt);
    rt_sat  = sat16(rt);
  end

  assign out_busy = out_valid_q && out_stall_i;
  assign out_wr   = ctl_i.out_en && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        hist_q[i] <= '0;
      end
      cnt_q       <= '0;
      stop_q      <= 1'b1;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        hist_q[0] <= e_new;
        for (int i = 1; i < DEPTH; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
        cnt_q  <= cnt_d;
        stop_q <= stop_d;
      end
      if (out_wr) begin
        prev_l_q    <= lt_sat;
        prev_r_q    <= rt_sat;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
    if (ctl_i.steer_en) begin
      steer_q <= steer_d;
    end
    if (ctl_i.mag_en) begin
      mag_q <= mag_d;
      neg_q <= pbs[26];
    end
    if (out_wr) begin
      out_word_q.steer_out    <= steer_q;
      out_word_q.left_target  <= lt_sat;
      out_word_q.right_target <= rt_sat;
      out_word_q.stopped      <= stop_q;
    end
  end

  assign stat_o.out_busy = out_busy;
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Testbench for steering_pid_differential_drive: directed and random control ticks
// checked word by word against an in-bench steering, wheel target and protection model.
// Depends on spdd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module testbench;
  import spdd_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t               cfg_q;
  logic signed [15:0] err_hist [HISTORY_DEPTH];
  logic [9:0]         protect_cnt;
  logic               stop_q;
  logic signed [15:0] prev_left;
  logic signed [15:0] prev_right;

  out_word_t pending_outputs[$];
  int fail_count = 0;
  int ticks_sent = 0;
  int words_checked = 0;
  int stop_events = 0;
  int settings_used = 0;
  int burst_left = 0;

  always #10 clk_i = ~clk_i;

  steering_pid_differential_drive u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  function automatic void reset_model();
    cfg_q = '{gain_p: 16'd256, gain_second_diff: 16'd0, gain_d: 16'd0, deriv_lag: 4'd1,
              steer_limit: 15'd1000, base_speed: 11'd0, protect_enable: 1'b1};
    for (int i = 0; i < HISTORY_DEPTH; i++) err_hist[i] = '0;
    protect_cnt = '0;
    stop_q = 1'b1;
    prev_left = '0;
    prev_right = '0;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void bump_protect();
    if (protect_cnt < COUNT_MAX) protect_cnt++;
  endfunction

  function automatic out_word_t steer_tick(in_word_t w);
    longint left_cnt, right_cnt, dl, dr, e0, raw, steer_v, lim, share, base;
    int lag;
    out_word_t r;
    left_cnt = longint'(w.count_left);
    right_cnt = longint'(w.count_right);
    if (w.release_stop) stop_q = 1'b0;
    if (protect_cnt >= PROTECT_LIMIT) begin
      if (!stop_q) stop_events++;
      stop_q = 1'b1;
      protect_cnt = '0;
    end
    if (cfg_q.protect_enable && !stop_q) begin
      dl = left_cnt - longint'(prev_left);
      dr = longint'(prev_right) - right_cnt;
      if ((dl < 0 ? -dl : dl) > TRACK_TOL || (dr < 0 ? -dr : dr) > TRACK_TOL) begin
        bump_protect();
      end else if (w.sensor_sum > LOST_LINE_SUM) begin
        protect_cnt = '0;
      end
    end
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
    e0 = longint'(ERR_SCALE) * (longint'(w.sensor_left) - longint'(w.sensor_right));
    err_hist[0] = e0[15:0];
    if (cfg_q.protect_enable && w.sensor_sum < LOST_LINE_SUM) bump_protect();
    lag = int'(cfg_q.deriv_lag);
    if (lag > HISTORY_DEPTH - 1) lag = HISTORY_DEPTH - 1;
    raw = longint'(cfg_q.gain_p) * e0
        + longint'(cfg_q.gain_second_diff)
          * (e0 - 2 * longint'(err_hist[1]) + longint'(err_hist[2]))
        + longint'(cfg_q.gain_d) * (e0 - longint'(err_hist[lag]));
    steer_v = raw / 256;
    lim = longint'(cfg_q.steer_limit);
    if (steer_v > lim) steer_v = lim;
    if (steer_v < -lim) steer_v = -lim;
    base = longint'(cfg_q.base_speed);
    share = (base * steer_v) / longint'(ERR_SCALE);
    prev_left = clip16(base - share);
    prev_right = clip16(base + share);
    r.steer_out = steer_v[15:0];
    r.left_target = prev_left;
    r.right_target = prev_right;
    r.stopped = stop_q;
    return r;
  endfunction

  function automatic in_word_t make_word(int sl, int sr, int sum, int cl, int cr, bit rel);
    in_word_t w;
    w.sensor_left = sl[7:0];
    w.sensor_right = sr[7:0];
    w.sensor_sum = sum[9:0];
    w.count_left = cl[11:0];
    w.count_right = cr[11:0];
    w.release_stop = rel;
    return w;
  endfunction

  function automatic int near_target(logic signed [15:0] t);
    int v;
    v = int'(t) + int'($urandom_range(0, 28)) - 14;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  function automatic in_word_t clean_tick(bit rel);
    int sum;
    sum = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 79) : $urandom_range(80, 1023);
    return make_word($urandom_range(0, 255), $urandom_range(0, 255), sum,
                     near_target(prev_left), near_target(prev_right), rel);
  endfunction

  function automatic in_word_t noise_tick();
    return make_word($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1023),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     1'($urandom_range(0, 1)));
  endfunction

  task automatic send_tick(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk_i); while (in_stall);
    pending_outputs.push_back(steer_tick(w));
    ticks_sent++;
    burst_left--;
  endtask

  task automatic let_block_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_GAIN_P:         cfg_q.gain_p = val;
      CFG_GAIN_SECOND:    cfg_q.gain_second_diff = val;
      CFG_GAIN_D:         cfg_q.gain_d = val;
      CFG_DERIV_LAG:      cfg_q.deriv_lag = val[3:0];
      CFG_STEER_LIMIT:    cfg_q.steer_limit = val[14:0];
      CFG_BASE_SPEED:     cfg_q.base_speed = val[10:0];
      CFG_PROTECT_ENABLE: cfg_q.protect_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(int gp, int gs, int gd, int lag, int lim, int base, int en);
    write_reg(CFG_GAIN_P, gp[15:0]);
    write_reg(CFG_GAIN_SECOND, gs[15:0]);
    write_reg(CFG_GAIN_D, gd[15:0]);
    write_reg(CFG_DERIV_LAG, lag[15:0]);
    write_reg(CFG_STEER_LIMIT, lim[15:0]);
    write_reg(CFG_BASE_SPEED, base[15:0]);
    write_reg(CFG_PROTECT_ENABLE, en[15:0]);
    settings_used++;
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(0, 512);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_value(int top);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return top;
      2:       return $urandom_range(0, top < 2000 ? top : 2000);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic test_reset_values();
    settings_used++;
    send_tick(make_word(255, 0, 1023, 0, 0, 1'b0));
    send_tick(make_word(0, 255, 0, -2048, 2047, 1'b1));
    send_tick(make_word(128, 128, 79, 2047, -2048, 1'b0));
    send_tick(make_word(10, 20, 80, 0, 0, 1'b0));
    send_tick(make_word(20, 10, 81, 0, 0, 1'b0));
    send_tick(make_word(1, 0, 500, 10, -10, 1'b0));
    send_tick(make_word(0, 1, 500, 11, -11, 1'b0));
  endtask

  task automatic test_gain_extremes();
    let_block_idle();
    write_all(65535, 65535, 65535, 0, 32767, 2047, 0);
    send_tick(make_word(255, 0, 1023, 2047, 2047, 1'b0));
    send_tick(make_word(0, 255, 0, -2048, -2048, 1'b0));
    send_tick(make_word(255, 0, 40, 0, 0, 1'b1));
    send_tick(make_word(0, 0, 100, 0, 0, 1'b0));
    send_tick(make_word(255, 255, 100, 0, 0, 1'b0));
    let_block_idle();
    write_all(65535, 65535, 65535, 15, 0, 1, 1);
    send_tick(make_word(0, 255, 300, 1, 1, 1'b0));
    send_tick(make_word(255, 0, 300, 1, 1, 1'b0));
    send_tick(make_word(0, 255, 300, 1, 1, 1'b0));
    let_block_idle();
    write_all(0, 1, 1, 9, 32767, 100, 1);
    send_tick(make_word(200, 3, 300, 100, 100, 1'b0));
    send_tick(make_word(3, 200, 300, 100, 100, 1'b0));
    send_tick(make_word(77, 77, 300, 100, 100, 1'b0));
  endtask

  task automatic test_protection_stop();
    int n;
    int events_at_start;
    let_block_idle();
    write_all(256, $urandom_range(0, 64), $urandom_range(0, 256), $urandom_range(1, 9),
              1000, 300, 1);
    send_tick(make_word($urandom_range(0, 255), $urandom_range(0, 255), 10, 0, 0, 1'b1));
    events_at_start = stop_events;
    n = 0;
    while (stop_events == events_at_start && n < 450) begin
      send_tick(make_word($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 79), $urandom_range(0, 4095),
                          $urandom_range(0, 4095), 1'b0));
      n++;
    end
    send_tick(clean_tick(1'b1));
    repeat (30) send_tick(clean_tick(1'b0));
  endtask

  task automatic test_random_ticks();
    for (int phase = 0; phase < 5; phase++) begin
      let_block_idle();
      write_all(pick_gain(), pick_gain(), pick_gain(), $urandom_range(0, 15),
                pick_value(32767), pick_value(2047), int'($urandom_range(0, 3) != 0));
      repeat (100) begin
        if ($urandom_range(0, 9) < 7) send_tick(clean_tick($urandom_range(0, 19) == 0));
        else send_tick(noise_tick());
      end
    end
  endtask

  initial begin
    stall_mode_e mode;
    int run_len;
    int phase_cnt;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      run_len = $urandom_range(10, 150);
      phase_cnt = 0;
      repeat (run_len) begin
        @(negedge clk_i);
        case (mode)
          STALL_NONE:     out_stall = 1'b0;
          STALL_LIGHT:    out_stall = ($urandom_range(0, 9) == 0);
          STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 6);
          STALL_PERIODIC: out_stall = ((phase_cnt % 16) < 5);
          default:        out_stall = 1'b0;
        endcase
        phase_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected output word %h", out_word);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        words_checked++;
        if (out_word.steer_out !== want.steer_out) begin
          $error("steer_out: expected %0d, actual %0d", want.steer_out, out_word.steer_out);
          fail_count++;
        end
        if (out_word.left_target !== want.left_target) begin
          $error("left_target: expected %0d, actual %0d", want.left_target,
                 out_word.left_target);
          fail_count++;
        end
        if (out_word.right_target !== want.right_target) begin
          $error("right_target: expected %0d, actual %0d", want.right_target,
                 out_word.right_target);
          fail_count++;
        end
        if (out_word.stopped !== want.stopped) begin
          $error("stopped: expected %0d, actual %0d", want.stopped, out_word.stopped);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_model();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_gain_extremes();
    test_protection_stop();
    test_random_ticks();

    @(negedge clk_i);
    in_valid = 1'b0;
    wait_cycles = 0;
    while (pending_outputs.size() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_outputs.size() != 0) begin
      $error("%0d output words never arrived", pending_outputs.size());
      fail_count++;
    end
    $display("Ran %0d control ticks under %0d register settings, %0d words checked,",
             ticks_sent, settings_used, words_checked);
    $display("with %0d protection stops raised by the lost-line and tracking counter.",
             stop_events);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
